// File: design/arp_rr_pkg.sv
// Shared types and constants for the ARP request responder.
package arp_rr_pkg;

  localparam int unsigned MacW      = 48;
  localparam int unsigned IpW       = 32;
  localparam int unsigned PosW      = 6;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 48;

  localparam int unsigned ReplyLen  = 28;
  localparam int unsigned ReplyIdxW = 5;
  localparam int unsigned ReplyBits = 8 * ReplyLen;

  localparam int unsigned JobDepth  = 2;
  localparam int unsigned JobPtrW   = 1;
  localparam int unsigned JobCntW   = 2;

  localparam logic [MacW-1:0] OwnMacRst = 48'hB42E_99EB_E942;
  localparam logic [IpW-1:0]  OwnIpRst  = 32'h0A00_0067;

  localparam logic [15:0] EthTypeArp   = 16'h0806;
  localparam logic [15:0] ArpOpRequest = 16'h0001;
  localparam logic [15:0] ArpOpReply   = 16'h0002;
  localparam logic [15:0] ArpHwEth     = 16'h0001;
  localparam logic [15:0] ArpProtoIpv4 = 16'h0800;
  localparam logic [7:0]  ArpHwLen     = 8'd6;
  localparam logic [7:0]  ArpProtoLen  = 8'd4;
  localparam logic [63:0] ReplyHdr     =
    {ArpHwEth, ArpProtoIpv4, ArpHwLen, ArpProtoLen, ArpOpReply};

  // Frame byte offsets of the captured fields.
  localparam logic [PosW-1:0] PosEthTypeLo = 6'd12;
  localparam logic [PosW-1:0] PosEthTypeHi = 6'd13;
  localparam logic [PosW-1:0] PosOpLo      = 6'd20;
  localparam logic [PosW-1:0] PosOpHi      = 6'd21;
  localparam logic [PosW-1:0] PosSndMacLo  = 6'd22;
  localparam logic [PosW-1:0] PosSndMacHi  = 6'd27;
  localparam logic [PosW-1:0] PosSndIpLo   = 6'd28;
  localparam logic [PosW-1:0] PosSndIpHi   = 6'd31;
  localparam logic [PosW-1:0] PosTgtIpLo   = 6'd38;
  localparam logic [PosW-1:0] PosTgtIpHi   = 6'd41;
  localparam logic [PosW-1:0] PosMax       = 6'd63;

  localparam logic [ReplyIdxW-1:0] ReplyIdxLast = 5'(ReplyLen - 1);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_OWN_MAC = 2'd0,
    CFG_OWN_IP  = 2'd1
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       frame_last;
  } frame_req_t;

  typedef struct packed {
    logic [7:0] reply_byte;
    logic       reply_last;
  } reply_t;

  typedef struct packed {
    logic [MacW-1:0] requester_mac;
    logic [IpW-1:0]  requester_ip;
  } job_t;

endpackage

// File: design/arp_rr_parser.sv
// Front end: walks the received frame and queues a reply job for a matching ARP request.
module arp_rr_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           frame_valid_i,
  output logic                           frame_ready_o,
  input  arp_rr_pkg::frame_req_t         frame_i,
  input  logic [arp_rr_pkg::IpW-1:0]     own_ip_i,
  output logic                           job_push_o,
  output arp_rr_pkg::job_t               job_o,
  input  logic                           job_full_i
);

  logic [arp_rr_pkg::PosW-1:0] pos_q, pos_d;
  logic [15:0]                 eth_q, eth_d, eth_cap;
  logic [15:0]                 op_q, op_d, op_cap;
  logic [arp_rr_pkg::MacW-1:0] mac_q, mac_d, mac_cap;
  logic [arp_rr_pkg::IpW-1:0]  sip_q, sip_d, sip_cap;
  logic [arp_rr_pkg::IpW-1:0]  tip_q, tip_d, tip_cap;
  logic                        accept;
  logic [7:0]                  b;

  assign frame_ready_o = !job_full_i;
  assign accept        = frame_valid_i && frame_ready_o;
  assign b             = frame_i.frame_byte;

  // Shift the current byte into whichever field owns this position.
  always_comb begin
    eth_cap = eth_q;
    op_cap  = op_q;
    mac_cap = mac_q;
    sip_cap = sip_q;
    tip_cap = tip_q;
    priority if (pos_q == arp_rr_pkg::PosEthTypeLo || pos_q == arp_rr_pkg::PosEthTypeHi) begin
      eth_cap = {eth_q[7:0], b};
    end else if (pos_q == arp_rr_pkg::PosOpLo || pos_q == arp_rr_pkg::PosOpHi) begin
      op_cap = {op_q[7:0], b};
    end else if (pos_q >= arp_rr_pkg::PosSndMacLo && pos_q <= arp_rr_pkg::PosSndMacHi) begin
      mac_cap = {mac_q[arp_rr_pkg::MacW-9:0], b};
    end else if (pos_q >= arp_rr_pkg::PosSndIpLo && pos_q <= arp_rr_pkg::PosSndIpHi) begin
      sip_cap = {sip_q[arp_rr_pkg::IpW-9:0], b};
    end else if (pos_q >= arp_rr_pkg::PosTgtIpLo && pos_q <= arp_rr_pkg::PosTgtIpHi) begin
      tip_cap = {tip_q[arp_rr_pkg::IpW-9:0], b};
    end else begin
      eth_cap = eth_q;
    end
  end

  assign job_push_o = accept && frame_i.frame_last &&
                      (pos_q >= arp_rr_pkg::PosTgtIpHi) &&
                      (eth_cap == arp_rr_pkg::EthTypeArp) &&
                      (op_cap == arp_rr_pkg::ArpOpRequest) &&
                      (tip_cap == own_ip_i);
  assign job_o.requester_mac = mac_cap;
  assign job_o.requester_ip  = sip_cap;

  always_comb begin
    pos_d = pos_q;
    eth_d = eth_q;
    op_d  = op_q;
    mac_d = mac_q;
    sip_d = sip_q;
    tip_d = tip_q;
    if (accept) begin
      if (frame_i.frame_last) begin
        // Drop all frame state at frame end.
        pos_d = '0;
        eth_d = '0;
        op_d  = '0;
        mac_d = '0;
        sip_d = '0;
        tip_d = '0;
      end else begin
        pos_d = (pos_q == arp_rr_pkg::PosMax) ? pos_q : pos_q + 1'b1;
        eth_d = eth_cap;
        op_d  = op_cap;
        mac_d = mac_cap;
        sip_d = sip_cap;
        tip_d = tip_cap;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      eth_q <= '0;
      op_q  <= '0;
      mac_q <= '0;
      sip_q <= '0;
      tip_q <= '0;
    end else begin
      pos_q <= pos_d;
      eth_q <= eth_d;
      op_q  <= op_d;
      mac_q <= mac_d;
      sip_q <= sip_d;
      tip_q <= tip_d;
    end
  end

endmodule

// File: design/arp_rr_job_fifo.sv
// Two-entry queue of pending reply jobs between the parser and the reply generator.
module arp_rr_job_fifo (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  arp_rr_pkg::job_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output arp_rr_pkg::job_t pop_data_o,
  output logic             valid_o
);

  arp_rr_pkg::job_t                 mem_q [arp_rr_pkg::JobDepth];
  logic [arp_rr_pkg::JobPtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [arp_rr_pkg::JobCntW-1:0]   cnt_q, cnt_d;

  assign full_o     = (cnt_q == arp_rr_pkg::JobCntW'(arp_rr_pkg::JobDepth));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    unique case ({push_i, pop_i})
      2'b10:   cnt_d = cnt_q + 1'b1;
      2'b01:   cnt_d = cnt_q - 1'b1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("job pushed into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o))
    else $error("job popped from empty queue");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= arp_rr_pkg::JobCntW'(arp_rr_pkg::JobDepth))
    else $error("job count out of range");

endmodule

// File: design/arp_rr_reply_gen.sv
// Back end: streams the 28-byte ARP reply for each queued job through an output register.
module arp_rr_reply_gen (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       job_valid_i,
  input  arp_rr_pkg::job_t           job_i,
  output logic                       job_pop_o,
  input  logic [arp_rr_pkg::MacW-1:0] own_mac_i,
  input  logic [arp_rr_pkg::IpW-1:0]  own_ip_i,
  output logic                       reply_valid_o,
  input  logic                       reply_ready_i,
  output arp_rr_pkg::reply_t         reply_o
);

  logic [arp_rr_pkg::ReplyIdxW-1:0] idx_q, idx_d;
  logic                             vld_q, vld_d;
  arp_rr_pkg::reply_t               out_q, out_d;
  logic [arp_rr_pkg::ReplyBits-1:0] reply_vec;
  logic [7:0]                       reply_bytes [arp_rr_pkg::ReplyLen];
  logic                             load;

  assign reply_vec = {arp_rr_pkg::ReplyHdr, own_mac_i, own_ip_i,
                      job_i.requester_mac, job_i.requester_ip};

  always_comb begin
    for (int k = 0; k < arp_rr_pkg::ReplyLen; k++) begin
      reply_bytes[k] = reply_vec[arp_rr_pkg::ReplyBits - 1 - 8 * k -: 8];
    end
  end

  // Advance one byte whenever a job is queued and the output register is free or being drained.
  assign load      = job_valid_i && (!vld_q || reply_ready_i);
  assign job_pop_o = load && (idx_q == arp_rr_pkg::ReplyIdxLast);

  always_comb begin
    idx_d = idx_q;
    vld_d = vld_q;
    out_d = out_q;
    if (load) begin
      idx_d            = (idx_q == arp_rr_pkg::ReplyIdxLast) ? '0 : idx_q + 1'b1;
      vld_d            = 1'b1;
      out_d.reply_byte = reply_bytes[idx_q];
      out_d.reply_last = (idx_q == arp_rr_pkg::ReplyIdxLast);
    end else if (reply_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  assign reply_valid_o = vld_q;
  assign reply_o       = out_q;

endmodule

// File: design/arp_request_responder_core.sv
// Top level of the ARP request responder: configuration registers and front/back wiring.
//
// Usage:
//   frame channel: one received Ethernet byte per request (frame_valid_i/frame_ready_o),
//   frame_last set on the final byte. Up to one byte is taken every cycle.
//   reply channel: the 28-byte ARP reply, one byte per request, reply_last on byte 28.
//   cfg channel: index 0 writes own MAC (48 bits), index 1 own IP (low 32 bits);
//   other indexes are ignored. Always ready; write only while the block is idle.
// Timing: the last frame byte of a qualifying request pushes a job into the job queue;
//   the output register then takes one reply byte per cycle while reply_ready_i is high.
// Throughput: the parser takes 1 byte per cycle; the reply generator emits 1 byte per
//   cycle. A two-entry job queue sits between them, so a qualifying frame of 42 or
//   more bytes never waits on a reply still in flight unless the queue is full.
// Stall: when the receiver holds reply_ready_i low the output register holds its byte;
//   the parser keeps taking bytes until the job queue fills, then drops frame_ready_o.
// Reset: rst_ni clears frame state, the queue and output valid; own MAC and IP return to
//   their default addresses.
module arp_request_responder_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                frame_valid_i,
  output logic                                frame_ready_o,
  input  arp_rr_pkg::frame_req_t              frame_i,
  output logic                                reply_valid_o,
  input  logic                                reply_ready_i,
  output arp_rr_pkg::reply_t                  reply_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [arp_rr_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [arp_rr_pkg::CfgDataW-1:0]     cfg_data_i
);

  logic [arp_rr_pkg::MacW-1:0] own_mac_q, own_mac_d;
  logic [arp_rr_pkg::IpW-1:0]  own_ip_q, own_ip_d;
  logic                        job_push, job_full, job_pop, job_valid;
  arp_rr_pkg::job_t            job_in, job_out;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    own_mac_d = own_mac_q;
    own_ip_d  = own_ip_q;
    if (cfg_valid_i) begin
      unique case (arp_rr_pkg::cfg_reg_e'(cfg_index_i))
        arp_rr_pkg::CFG_OWN_MAC: own_mac_d = cfg_data_i[arp_rr_pkg::MacW-1:0];
        arp_rr_pkg::CFG_OWN_IP:  own_ip_d  = cfg_data_i[arp_rr_pkg::IpW-1:0];
        default:                 own_mac_d = own_mac_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_mac_q <= arp_rr_pkg::OwnMacRst;
      own_ip_q  <= arp_rr_pkg::OwnIpRst;
    end else begin
      own_mac_q <= own_mac_d;
      own_ip_q  <= own_ip_d;
    end
  end

  arp_rr_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid_i),
    .frame_ready_o (frame_ready_o),
    .frame_i       (frame_i),
    .own_ip_i      (own_ip_q),
    .job_push_o    (job_push),
    .job_o         (job_in),
    .job_full_i    (job_full)
  );

  arp_rr_job_fifo u_job_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (job_push),
    .push_data_i (job_in),
    .full_o      (job_full),
    .pop_i       (job_pop),
    .pop_data_o  (job_out),
    .valid_o     (job_valid)
  );

  arp_rr_reply_gen u_reply_gen (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_valid_i   (job_valid),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .own_mac_i     (own_mac_q),
    .own_ip_i      (own_ip_q),
    .reply_valid_o (reply_valid_o),
    .reply_ready_i (reply_ready_i),
    .reply_o       (reply_o)
  );

endmodule
